FILE: sv/xte_pkg.sv
// Shared types, codes and entity tables for the XML text escaper.
`timescale 1ns / 1ps

package xte_pkg;

   // request function codes
   localparam logic [1:0] FN_CONTENT = 2'd0;
   localparam logic [1:0] FN_ATTR    = 2'd1;
   localparam logic [1:0] FN_END     = 2'd2;
   localparam logic [1:0] FN_CLEAR   = 2'd3;

   // result status codes
   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_DROP = 2'd1;
   localparam logic [1:0] ST_FAIL = 2'd2;

   localparam logic [1:0] BRACKET_MAX = 2'd2;

   // job queue between front and back
   localparam int QDEPTH = 2;
   localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   typedef enum logic [2:0] {
      CL_INVALID,
      CL_NORMAL,
      CL_NUL,
      CL_QUOTE,
      CL_AMP,
      CL_LESS,
      CL_GREATER
   } cls_type;

   typedef enum logic [2:0] {
      ENT_NONE,
      ENT_QUOT,
      ENT_AMP,
      ENT_LT,
      ENT_GT
   } ent_type;

   // one unit of work for the back end: either a single beat or an entity
   typedef struct packed {
      logic [7:0] data;
      logic       data_valid;
      logic [1:0] status;
      ent_type    ent;
   } job_type;

   function automatic cls_type classify(input logic [7:0] b);
      cls_type c;
      c = CL_NORMAL;
      if (b == 8'h00) begin
         c = CL_NUL;
      end else if (b inside {8'h09, 8'h0A, 8'h0D}) begin
         c = CL_NORMAL;
      end else if (b < 8'h20) begin
         c = CL_INVALID;
      end else if (b inside {8'hC0, 8'hC1, [8'hF5:8'hFF]}) begin
         c = CL_INVALID;
      end else if (b == 8'h22) begin
         c = CL_QUOTE;
      end else if (b == 8'h26) begin
         c = CL_AMP;
      end else if (b == 8'h3C) begin
         c = CL_LESS;
      end else if (b == 8'h3E) begin
         c = CL_GREATER;
      end
      return c;
   endfunction

   function automatic logic [2:0] ent_len(input ent_type e);
      logic [2:0] n;
      case (e)
         ENT_QUOT: n = 3'd6;
         ENT_AMP:  n = 3'd5;
         ENT_LT:   n = 3'd4;
         ENT_GT:   n = 3'd4;
         default:  n = 3'd1;
      endcase
      return n;
   endfunction

   function automatic logic [7:0] ent_char(input ent_type e, input logic [2:0] idx);
      logic [7:0] ch;
      ch = 8'h26; // '&' opens every entity
      case (e)
         ENT_QUOT: begin
            case (idx)
               3'd1:    ch = 8'h71; // q
               3'd2:    ch = 8'h75; // u
               3'd3:    ch = 8'h6F; // o
               3'd4:    ch = 8'h74; // t
               3'd5:    ch = 8'h3B; // ;
               default: ch = 8'h26;
            endcase
         end
         ENT_AMP: begin
            case (idx)
               3'd1:    ch = 8'h61; // a
               3'd2:    ch = 8'h6D; // m
               3'd3:    ch = 8'h70; // p
               3'd4:    ch = 8'h3B;
               default: ch = 8'h26;
            endcase
         end
         ENT_LT: begin
            case (idx)
               3'd1:    ch = 8'h6C; // l
               3'd2:    ch = 8'h74; // t
               3'd3:    ch = 8'h3B;
               default: ch = 8'h26;
            endcase
         end
         ENT_GT: begin
            case (idx)
               3'd1:    ch = 8'h67; // g
               3'd2:    ch = 8'h74; // t
               3'd3:    ch = 8'h3B;
               default: ch = 8'h26;
            endcase
         end
         default: ch = 8'h26;
      endcase
      return ch;
   endfunction

endpackage

FILE: sv/xte_if.sv
// Valid/ready channel interfaces for escaper requests and responses.
`timescale 1ns / 1ps

interface xte_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] func;
   logic [7:0] data_byte;

   modport source (output valid, output func, output data_byte, input ready);
   modport sink   (input valid, input func, input data_byte, output ready);
endinterface

interface xte_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       byte_valid;
   logic [1:0] status;
   logic       last;

   modport source (output valid, output out_byte, output byte_valid, output status,
                   output last, input ready);
   modport sink   (input valid, input out_byte, input byte_valid, input status,
                   input last, output ready);
endinterface

FILE: sv/xml_text_escaper.sv
// XML text escaper top level: front end, job queue and back end.
// An accepted beat goes into the job queue, then the back-end output register.
// Throughput: one request beat per cycle while each yields a single response beat
// and rsp is ready; an entity holds the back end for 4 to 6 beats, one per cycle.
// The two-entry job queue absorbs short stalls on either side.
// Reset (synchronous) clears fail flag, bracket count, stopped flag and the queue.
`timescale 1ns / 1ps

module xml_text_escaper (
   input  logic      clock,
   input  logic      reset,
   xte_req_if.sink   req_chan,
   xte_rsp_if.source rsp_chan
);
   import xte_pkg::*;

   logic    fq_valid, fq_ready;
   job_type fq_job;
   logic    qb_valid, qb_ready;
   job_type qb_job;

   xte_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .job_valid (fq_valid),
      .job_ready (fq_ready),
      .job       (fq_job)
   );

   xte_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fq_valid),
      .push_ready (fq_ready),
      .push_job   (fq_job),
      .pop_valid  (qb_valid),
      .pop_ready  (qb_ready),
      .pop_job    (qb_job)
   );

   xte_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (qb_valid),
      .job_ready (qb_ready),
      .job       (qb_job),
      .rsp_chan  (rsp_chan)
   );

endmodule

FILE: sv/xte_front.sv
// Front end: accepts request beats, classifies bytes, keeps run state, issues jobs.
`timescale 1ns / 1ps

module xte_front (
   input  logic             clock,
   input  logic             reset,
   xte_req_if.sink          req_chan,
   output logic             job_valid,
   input  logic             job_ready,
   output xte_pkg::job_type job
);
   import xte_pkg::*;

   logic       fail_ff, fail_in;
   logic [1:0] bracket_ff, bracket_in;
   logic       stopped_ff, stopped_in;
   logic       accept;
   cls_type    cls;
   logic       content;

   assign req_chan.ready = job_ready;
   assign job_valid      = req_chan.valid;
   assign accept         = req_chan.valid && job_ready;
   assign content        = (req_chan.func == FN_CONTENT);

   always_comb begin
      cls        = classify(req_chan.data_byte);
      fail_in    = fail_ff;
      bracket_in = bracket_ff;
      stopped_in = stopped_ff;
      job        = '{data: 8'h00, data_valid: 1'b0, status: ST_OK, ent: ENT_NONE};

      case (req_chan.func)
         FN_CLEAR: begin
            fail_in    = 1'b0;
            bracket_in = 2'd0;
            stopped_in = 1'b0;
         end
         FN_END: begin
            stopped_in = 1'b0;
            job.status = fail_ff ? ST_FAIL : ST_OK;
         end
         default: begin
            if (fail_ff) begin
               job.status = ST_FAIL;
            end else if (stopped_ff) begin
               job.status = ST_DROP;
            end else begin
               case (cls)
                  CL_INVALID: begin
                     fail_in    = 1'b1;
                     job.status = ST_FAIL;
                  end
                  CL_NUL: begin
                     stopped_in = 1'b1;
                     job.status = ST_DROP;
                  end
                  CL_AMP: begin
                     job.ent = ENT_AMP;
                     if (content) bracket_in = 2'd0;
                  end
                  CL_LESS: begin
                     job.ent = ENT_LT;
                     if (content) bracket_in = 2'd0;
                  end
                  CL_QUOTE: begin
                     if (content) begin
                        job.data       = req_chan.data_byte;
                        job.data_valid = 1'b1;
                        bracket_in     = 2'd0;
                     end else begin
                        job.ent = ENT_QUOT;
                     end
                  end
                  CL_GREATER: begin
                     if (content && bracket_ff == BRACKET_MAX) begin
                        job.ent    = ENT_GT;
                        bracket_in = 2'd0;
                     end else begin
                        job.data       = req_chan.data_byte;
                        job.data_valid = 1'b1;
                        if (content) bracket_in = 2'd0;
                     end
                  end
                  default: begin
                     job.data       = req_chan.data_byte;
                     job.data_valid = 1'b1;
                     if (content) begin
                        if (req_chan.data_byte == 8'h5D) begin // ']'
                           bracket_in = (bracket_ff == BRACKET_MAX) ? BRACKET_MAX
                                                                    : bracket_ff + 2'd1;
                        end else begin
                           bracket_in = 2'd0;
                        end
                     end
                  end
               endcase
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fail_ff    <= 1'b0;
         bracket_ff <= 2'd0;
         stopped_ff <= 1'b0;
      end else if (accept) begin
         fail_ff    <= fail_in;
         bracket_ff <= bracket_in;
         stopped_ff <= stopped_in;
      end
   end

endmodule

FILE: sv/xte_queue.sv
// Short job queue between front and back ends.
`timescale 1ns / 1ps

module xte_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  xte_pkg::job_type push_job,
   output logic             pop_valid,
   input  logic             pop_ready,
   output xte_pkg::job_type pop_job
);
   import xte_pkg::*;

   job_type             slot_ff [QDEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                push, pop;

   assign push_ready = (count_ff != QCNT_W'(QDEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_job    = slot_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= push_job;
   end

endmodule

FILE: sv/xte_back.sv
// Back end: expands jobs into response beats through an output register.
`timescale 1ns / 1ps

module xte_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             job_valid,
   output logic             job_ready,
   input  xte_pkg::job_type job,
   xte_rsp_if.source        rsp_chan
);
   import xte_pkg::*;

   logic [2:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       bvalid_ff, bvalid_in;
   logic [1:0] status_ff, status_in;
   logic       last_ff, last_in;
   logic       load;
   logic       final_beat;

   assign load       = job_valid && (!valid_ff || rsp_chan.ready);
   assign final_beat = (job.ent == ENT_NONE) || (idx_ff == ent_len(job.ent) - 3'd1);
   assign job_ready  = load && final_beat;

   always_comb begin
      valid_in  = valid_ff && !rsp_chan.ready;
      idx_in    = idx_ff;
      byte_in   = byte_ff;
      bvalid_in = bvalid_ff;
      status_in = status_ff;
      last_in   = last_ff;
      if (load) begin
         valid_in = 1'b1;
         idx_in   = final_beat ? 3'd0 : idx_ff + 3'd1;
         last_in  = final_beat;
         if (job.ent == ENT_NONE) begin
            byte_in   = job.data;
            bvalid_in = job.data_valid;
            status_in = job.status;
         end else begin
            byte_in   = ent_char(job.ent, idx_ff);
            bvalid_in = 1'b1;
            status_in = ST_OK;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 3'd0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff   <= byte_in;
      bvalid_ff <= bvalid_in;
      status_ff <= status_in;
      last_ff   <= last_in;
   end

   assign rsp_chan.valid      = valid_ff;
   assign rsp_chan.out_byte   = byte_ff;
   assign rsp_chan.byte_valid = bvalid_ff;
   assign rsp_chan.status     = status_ff;
   assign rsp_chan.last       = last_ff;

endmodule

FILE: sv/xte_checker.sv
// Port-level assertions for the XML text escaper, bound to the top level.
`timescale 1ns / 1ps

module xte_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_byte_valid,
   input logic [1:0] rsp_status,
   input logic       rsp_last
);
   import xte_pkg::*;

   // a stalled response beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte) && $stable(rsp_last))
      else $error("stalled response beat changed");

   // beats without a byte stand alone
   a_empty_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_byte_valid |-> rsp_last)
      else $error("empty response beat not marked last");

   // emitted bytes only ever carry ok status
   a_byte_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_byte_valid |-> rsp_status == ST_OK)
      else $error("emitted byte with bad status");

   // nothing is presented straight after reset
   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind xml_text_escaper xte_checker u_xte_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_out_byte   (rsp_chan.out_byte),
   .rsp_byte_valid (rsp_chan.byte_valid),
   .rsp_status     (rsp_chan.status),
   .rsp_last       (rsp_chan.last)
);

FILE: tb/escape_checker.sv
// Watches the escaper channels, predicts every response beat and compares it.
`timescale 1ns / 1ps

module escape_checker (
   input  logic clock,
   input  logic reset,
   xte_req_if   req,
   xte_rsp_if   rsp,
   output int   fail_count,
   output int   pending
);
   import xte_pkg::*;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic [1:0] status;
      logic       last;
   } escaped_beat_type;

   escaped_beat_type escaped_beats_due[$];
   escaped_beat_type due;
   escaped_beat_type seen;

   // mirror of the escaper state
   logic       failed;
   logic [1:0] bracket_count;
   logic       run_dropped;

   int mismatches;
   int beat_index;

   function automatic escaped_beat_type make_beat(input logic [7:0] b, input logic v,
                                                  input logic [1:0] st, input logic lst);
      escaped_beat_type eb;
      eb.out_byte   = v ? b : 8'h00;
      eb.byte_valid = v;
      eb.status     = st;
      eb.last       = lst;
      return eb;
   endfunction

   // append one predicted beat at the tail
   task automatic queue_beat(input escaped_beat_type eb);
      escaped_beats_due = {escaped_beats_due, eb};
   endtask

   task automatic escape_item(input logic [1:0] fn, input logic [7:0] b);
      cls_type cls;
      string   ent;
      logic    in_content;
      int      i;
      in_content = (fn == FN_CONTENT);
      ent = "";
      if (fn == FN_CLEAR) begin
         failed = 1'b0;
         bracket_count = 2'd0;
         run_dropped = 1'b0;
         queue_beat(make_beat(8'h00, 1'b0, ST_OK, 1'b1));
      end else if (fn == FN_END) begin
         run_dropped = 1'b0;
         queue_beat(make_beat(8'h00, 1'b0, failed ? ST_FAIL : ST_OK, 1'b1));
      end else if (failed) begin
         queue_beat(make_beat(8'h00, 1'b0, ST_FAIL, 1'b1));
      end else if (run_dropped) begin
         queue_beat(make_beat(8'h00, 1'b0, ST_DROP, 1'b1));
      end else begin
         if (b == 8'h00) begin
            cls = CL_NUL;
         end else if (b == 8'h09 || b == 8'h0A || b == 8'h0D) begin
            cls = CL_NORMAL;
         end else if (b < 8'h20 || b == 8'hC0 || b == 8'hC1 || b >= 8'hF5) begin
            cls = CL_INVALID;
         end else if (b == 8'h22) begin
            cls = CL_QUOTE;
         end else if (b == 8'h26) begin
            cls = CL_AMP;
         end else if (b == 8'h3C) begin
            cls = CL_LESS;
         end else if (b == 8'h3E) begin
            cls = CL_GREATER;
         end else begin
            cls = CL_NORMAL;
         end

         if (cls == CL_INVALID) begin
            failed = 1'b1;
            queue_beat(make_beat(8'h00, 1'b0, ST_FAIL, 1'b1));
         end else if (cls == CL_NUL) begin
            run_dropped = 1'b1;
            queue_beat(make_beat(8'h00, 1'b0, ST_DROP, 1'b1));
         end else begin
            // quote only expands in attributes, '>' only after "]]" in content
            if (cls == CL_QUOTE && in_content) begin
               cls = CL_NORMAL;
            end
            if (cls == CL_GREATER && !(in_content && bracket_count == BRACKET_MAX)) begin
               cls = CL_NORMAL;
            end
            case (cls)
               CL_QUOTE:   ent = "&quot;";
               CL_AMP:     ent = "&amp;";
               CL_LESS:    ent = "&lt;";
               CL_GREATER: ent = "&gt;";
               default:    ent = "";
            endcase
            if (ent.len() == 0) begin
               if (in_content) begin
                  if (b == 8'h5D) begin
                     bracket_count = (bracket_count == BRACKET_MAX) ? BRACKET_MAX
                                                                   : bracket_count + 2'd1;
                  end else begin
                     bracket_count = 2'd0;
                  end
               end
               queue_beat(make_beat(b, 1'b1, ST_OK, 1'b1));
            end else begin
               for (i = 0; i < ent.len(); i++) begin
                  queue_beat(make_beat(ent[i], 1'b1, ST_OK, i == ent.len() - 1));
               end
               if (in_content) begin
                  bracket_count = 2'd0;
               end
            end
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         escaped_beats_due.delete();
         failed = 1'b0;
         bracket_count = 2'd0;
         run_dropped = 1'b0;
      end else begin
         if (req.valid && req.ready) begin
            escape_item(req.func, req.data_byte);
         end
         if (rsp.valid && rsp.ready) begin
            seen.out_byte   = rsp.out_byte;
            seen.byte_valid = rsp.byte_valid;
            seen.status     = rsp.status;
            seen.last       = rsp.last;
            if (escaped_beats_due.size() == 0) begin
               if (mismatches < 10) begin
                  $display("%0t: unexpected beat %0d: byte %02h valid %0b status %0d last %0b",
                           $realtime, beat_index, seen.out_byte, seen.byte_valid,
                           seen.status, seen.last);
               end
               mismatches++;
            end else begin
               due = escaped_beats_due.pop_front();
               if (seen.out_byte !== due.out_byte || seen.byte_valid !== due.byte_valid ||
                   seen.status !== due.status || seen.last !== due.last) begin
                  if (mismatches < 10) begin
                     $display("%0t: beat %0d expected byte %02h valid %0b status %0d last %0b",
                              $realtime, beat_index, due.out_byte, due.byte_valid,
                              due.status, due.last);
                     $display("%0t: beat %0d      got byte %02h valid %0b status %0d last %0b",
                              $realtime, beat_index, seen.out_byte, seen.byte_valid,
                              seen.status, seen.last);
                  end
                  mismatches++;
               end
            end
            beat_index++;
         end
      end
      pending    <= escaped_beats_due.size();
      fail_count <= mismatches;
   end

endmodule

FILE: tb/testbench.sv
// Top of the escaper testbench: clock, reset, request stimulus, response stalls, verdict.
`timescale 1ns / 1ps

module testbench;
   import xte_pkg::*;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int DIRECTED_LEN  = 25;
   localparam int RANDOM_ITEMS  = 345;
   localparam int DRAIN_CYCLES  = 20;

   logic clock;
   logic reset;

   int idle_pct;
   int stall_pct;
   int items_sent;
   int cycle_count;
   int fail_count;
   int pending;

   xte_req_if req_chan ();
   xte_rsp_if rsp_chan ();

   xml_text_escaper u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   escape_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req        (req_chan),
      .rsp        (rsp_chan),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_chan.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // one request beat, with random idle cycles in front of it
   task automatic send_beat(input logic [1:0] fn, input logic [7:0] b);
      while ($urandom_range(99) < idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.func      <= fn;
      req_chan.data_byte <= b;
      @(posedge clock);
      while (!req_chan.ready) begin
         @(posedge clock);
      end
      items_sent++;
   endtask

   function automatic logic [7:0] pick_text_byte();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 35) return 8'($urandom_range(126, 32));
      if (roll < 50) return 8'h5D;
      if (roll < 58) return 8'h3E;
      if (roll < 64) return 8'h22;
      if (roll < 70) return 8'h26;
      if (roll < 76) return 8'h3C;
      if (roll < 82) begin
         roll = $urandom_range(2);
         return (roll == 0) ? 8'h09 : (roll == 1) ? 8'h0A : 8'h0D;
      end
      if (roll < 90) return 8'($urandom_range(244, 128));
      if (roll < 93) return 8'h00;
      if (roll < 96) begin
         roll = $urandom_range(3);
         return (roll == 0) ? 8'($urandom_range(31, 1)) :
                (roll == 1) ? 8'($urandom_range(255, 245)) :
                (roll == 2) ? 8'hC0 : 8'hC1;
      end
      return 8'($urandom);
   endfunction

   // a text run of one kind, a few strays of either kind, then mostly its close
   task automatic send_text_run();
      int unsigned run_len;
      int unsigned roll;
      logic [1:0]  fn;
      int          k;
      run_len = $urandom_range(12, 1);
      fn = ($urandom_range(2) == 0) ? FN_ATTR : FN_CONTENT;
      for (k = 0; k < run_len; k++) begin
         if ($urandom_range(9) == 0) begin
            send_beat(($urandom_range(1) == 0) ? FN_CONTENT : FN_ATTR, pick_text_byte());
         end else begin
            send_beat(fn, pick_text_byte());
         end
      end
      roll = $urandom_range(99);
      if (roll < 80) begin
         send_beat(FN_END, 8'($urandom));
      end else if (roll < 90) begin
         send_beat(FN_CLEAR, 8'($urandom));
      end
      if ($urandom_range(3) == 0) begin
         send_beat(FN_CLEAR, 8'($urandom));
      end
   endtask

   initial begin
      reset              <= 1'b1;
      req_chan.valid     <= 1'b0;
      req_chan.func      <= FN_CONTENT;
      req_chan.data_byte <= 8'h00;
      idle_pct   = 27;
      stall_pct  = 88;
      items_sent = 0;
      cycle_count = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed part
      send_beat(FN_CLEAR,   8'hFF);
      send_beat(FN_CONTENT, 8'h20);
      send_beat(FN_CONTENT, 8'h5D);
      send_beat(FN_ATTR,    8'h5D);  // attribute bracket leaves the count alone
      send_beat(FN_END,     8'h00);
      send_beat(FN_CONTENT, 8'h5D);  // count carries over the end of run
      send_beat(FN_CONTENT, 8'h3E);
      send_beat(FN_ATTR,    8'h22);
      send_beat(FN_CONTENT, 8'h22);
      send_beat(FN_ATTR,    8'h3E);
      send_beat(FN_CONTENT, 8'h26);
      send_beat(FN_ATTR,    8'h3C);
      send_beat(FN_CONTENT, 8'h09);
      send_beat(FN_ATTR,    8'h0A);
      send_beat(FN_CONTENT, 8'h0D);
      send_beat(FN_CONTENT, 8'hF4);
      send_beat(FN_CONTENT, 8'h00);
      send_beat(FN_ATTR,    8'hFF);  // dropped, not failed
      send_beat(FN_END,     8'hFF);
      send_beat(FN_CONTENT, 8'hC1);
      send_beat(FN_ATTR,    8'h78);
      send_beat(FN_END,     8'h00);
      send_beat(FN_CLEAR,   8'h00);
      send_beat(FN_CONTENT, 8'hF5);
      send_beat(FN_CLEAR,   8'h00);

      while (items_sent < DIRECTED_LEN + RANDOM_ITEMS / 3) begin
         send_text_run();
      end
      idle_pct  = 88;
      stall_pct = 27;
      while (items_sent < DIRECTED_LEN + 2 * RANDOM_ITEMS / 3) begin
         send_text_run();
      end
      idle_pct  = 0;
      stall_pct = 0;
      while (items_sent < DIRECTED_LEN + RANDOM_ITEMS) begin
         send_text_run();
      end
      req_chan.valid <= 1'b0;

      @(posedge clock);
      while (pending != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
